FILE: hdl/wsaq_pkg.sv
// Package for the wrapped summed-area query unit.
// Holds shared types, register indexes and mode codes; no dependencies.
`default_nettype none

package wsaq_pkg;

	localparam int SumW = 48;

	typedef logic signed [10:0] coord_t;

	localparam coord_t BORDER = -11'sd1;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	localparam logic CFG_GRID_COLS = 1'b0;
	localparam logic CFG_GRID_ROWS = 1'b1;

	localparam logic [2:0] STEP_LAST = 3'd7;

	// Up to two rectangles per query item.
	typedef struct packed {
		coord_t w0;
		coord_t e0;
		coord_t w1;
		coord_t e1;
		coord_t n;
		coord_t s;
		logic   two;
	} rect_pair_t;

	typedef struct packed {
		logic sub;
		logic zero;
	} pt_flags_t;

	typedef struct packed {
		logic [SumW-1:0] a;
		logic [SumW-1:0] b;
		logic            sub;
	} alu_req_t;

endpackage

`default_nettype wire

FILE: hdl/wsaq_item_if.sv
// Input channel interface: valid/ready handshake plus load and query fields.
// Depends on nothing.
`default_nettype none

interface wsaq_item_if;
	logic               valid;
	logic               ready;
	logic               mode;
	logic signed [31:0] pixel_value;
	logic        [7:0]  center_x;
	logic        [7:0]  center_y;
	logic signed [8:0]  west_offset;
	logic        [7:0]  east_offset;
	logic signed [8:0]  north_offset;
	logic signed [8:0]  south_offset;
	logic               last_row;

	modport source (
		output valid, mode, pixel_value, center_x, center_y, west_offset,
		       east_offset, north_offset, south_offset, last_row,
		input  ready
	);

	modport sink (
		input  valid, mode, pixel_value, center_x, center_y, west_offset,
		       east_offset, north_offset, south_offset, last_row,
		output ready
	);
endinterface

`default_nettype wire

FILE: hdl/wsaq_result_if.sv
// Output channel interface: valid/ready handshake plus the kernel total.
// Depends on nothing.
`default_nettype none

interface wsaq_result_if;
	logic        valid;
	logic        ready;
	logic [47:0] total_sum;

	modport source (output valid, total_sum, input ready);
	modport sink (input valid, total_sum, output ready);
endinterface

`default_nettype wire

FILE: hdl/wsaq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
`default_nettype none

module wsaq_ram #(
	parameter int Width = 48,
	parameter int Depth = 65536
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);

	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: hdl/wsaq_alu.sv
// Shared 48-bit add/subtract unit used by both table build and query.
// Depends on wsaq_pkg.
`default_nettype none

module wsaq_alu (
	input  wire wsaq_pkg::alu_req_t          req,
	output logic [wsaq_pkg::SumW-1:0]        sum
);

	always_comb begin
		sum = req.a + (req.b ^ {wsaq_pkg::SumW{req.sub}}) + {{(wsaq_pkg::SumW-1){1'b0}}, req.sub};
	end

endmodule

`default_nettype wire

FILE: hdl/wsaq_point.sv
// Corner generator: maps a query step to a clamped table address and sign.
// Depends on wsaq_pkg.
`default_nettype none

module wsaq_point #(
	parameter int ColW = 8,
	parameter int RowW = 8
) (
	input  wire logic [2:0]               step,
	input  wire wsaq_pkg::rect_pair_t     rects,
	input  wire logic [8:0]               cols,
	input  wire logic [8:0]               rows,
	output logic [RowW+ColW-1:0]          addr,
	output wsaq_pkg::pt_flags_t           flags
);

	wsaq_pkg::coord_t x;
	wsaq_pkg::coord_t y;
	wsaq_pkg::coord_t cs;
	wsaq_pkg::coord_t rs;
	wsaq_pkg::coord_t xc;
	wsaq_pkg::coord_t yc;

	always_comb begin
		cs = $signed({2'b00, cols});
		rs = $signed({2'b00, rows});
		// corners: (E,S)+ (E,N)- (W,S)- (W,N)+
		if (step[1]) begin
			x = step[2] ? rects.w1 : rects.w0;
		end else begin
			x = step[2] ? rects.e1 : rects.e0;
		end
		y = step[0] ? rects.n : rects.s;
		flags.sub  = step[1] ^ step[0];
		flags.zero = (x < 0) || (y < 0) || (step[2] && !rects.two);
		xc = (x >= cs) ? cs - 11'sd1 : x;
		yc = (y >= rs) ? rs - 11'sd1 : y;
		addr = {RowW'($unsigned(yc)), ColW'($unsigned(xc))};
	end

endmodule

`default_nettype wire

FILE: hdl/wrapped_summed_area_query_unit.sv
// Top level of the wrapped summed-area query unit.
// Depends on wsaq_pkg, wsaq_item_if, wsaq_result_if, wsaq_ram, wsaq_alu, wsaq_point.
`default_nettype none

// One item at a time; item.ready is high only while idle. A load item passes
// through acceptance, a read of the left neighbor, then a write of the new
// table entry; a query item issues eight corner reads one per cycle through
// the single RAM read port, then a drain state folds in the last read, and the
// last kernel rectangle waits in an emit state to hand its total to the output register.
// The output register lets the next item be taken while a total still waits.
// Table entries are valid only once written by a full load; no clearing pass.

module wrapped_summed_area_query_unit #(
	parameter int MAX_COLS = 256,
	parameter int MAX_ROWS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [8:0]  wr_data,
	wsaq_item_if.sink        item,
	wsaq_result_if.source    result
);

	localparam int ColW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int RowW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int AddrW = ColW + RowW;
	localparam int SumW  = wsaq_pkg::SumW;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_LADD   = 3'd1;
	localparam logic [2:0] ST_LWR    = 3'd2;
	localparam logic [2:0] ST_QRUN   = 3'd3;
	localparam logic [2:0] ST_QDRAIN = 3'd4;
	localparam logic [2:0] ST_EMIT   = 3'd5;

	logic [2:0]             state_q;
	logic [2:0]             step_q;
	logic [8:0]             grid_cols_q;
	logic [8:0]             grid_rows_q;
	logic [ColW-1:0]        load_col_q;
	logic [RowW-1:0]        load_row_q;
	logic [SumW-1:0]        crs_q;
	logic [SumW-1:0]        total_q;
	logic                   out_valid_q;
	logic [SumW-1:0]        out_data_q;
	logic [31:0]            val_q;
	wsaq_pkg::rect_pair_t   rects_q;
	logic                   last_q;
	logic                   v_s1;
	wsaq_pkg::pt_flags_t    flags_s1;

	logic [8:0]             cols;
	logic [8:0]             rows;
	logic                   row_wrap;
	logic                   col_wrap;
	wsaq_pkg::rect_pair_t   rects_in;
	wsaq_pkg::pt_flags_t    pt_flags;
	logic [AddrW-1:0]       pt_addr;
	logic [AddrW-1:0]       raddr;
	logic [SumW-1:0]        rdata;
	logic                   ram_we;
	wsaq_pkg::alu_req_t     alu_req;
	logic [SumW-1:0]        alu_sum;
	logic                   emit_go;

	wsaq_pkg::coord_t cx, cy, wpos, epos, cs;

	assign item.ready       = (state_q == ST_IDLE);
	assign result.valid     = out_valid_q;
	assign result.total_sum = out_data_q;

	always_comb begin
		if (grid_cols_q < 9'd2) begin
			cols = 9'd2;
		end else if (32'(grid_cols_q) > MAX_COLS) begin
			cols = 9'(MAX_COLS);
		end else begin
			cols = grid_cols_q;
		end
		if (grid_rows_q == 9'd0) begin
			rows = 9'd1;
		end else if (32'(grid_rows_q) > MAX_ROWS) begin
			rows = 9'(MAX_ROWS);
		end else begin
			rows = grid_rows_q;
		end
		row_wrap = (32'(load_row_q) + 32'd1) >= 32'(rows);
		col_wrap = (32'(load_col_q) + 32'd1) >= 32'(cols);
	end

	// Rectangle split decode at acceptance.
	always_comb begin
		cx   = $signed({3'b000, item.center_x});
		cy   = $signed({3'b000, item.center_y});
		cs   = $signed({2'b00, cols});
		wpos = cx + 11'(item.west_offset);
		epos = cx + $signed({3'b000, item.east_offset});
		rects_in.n   = cy + 11'(item.north_offset);
		rects_in.s   = cy + 11'(item.south_offset);
		rects_in.w1  = wsaq_pkg::BORDER;
		rects_in.e1  = wsaq_pkg::BORDER;
		rects_in.two = 1'b0;
		if (item.east_offset == cols[8:1]) begin
			rects_in.w0 = wsaq_pkg::BORDER;
			rects_in.e0 = cs - 11'sd1;
		end else if (wpos < wsaq_pkg::BORDER) begin
			rects_in.w0  = wsaq_pkg::BORDER;
			rects_in.e0  = epos;
			rects_in.w1  = cs + wpos;
			rects_in.e1  = cs - 11'sd1;
			rects_in.two = 1'b1;
		end else if (epos >= cs) begin
			rects_in.w0  = wpos;
			rects_in.e0  = cs - 11'sd1;
			rects_in.w1  = wsaq_pkg::BORDER;
			rects_in.e1  = epos - cs;
			rects_in.two = 1'b1;
		end else begin
			rects_in.w0 = wpos;
			rects_in.e0 = epos;
		end
	end

	wsaq_point #(
		.ColW (ColW),
		.RowW (RowW)
	) u_point (
		.step  (step_q),
		.rects (rects_q),
		.cols  (cols),
		.rows  (rows),
		.addr  (pt_addr),
		.flags (pt_flags)
	);

	always_comb begin
		alu_req.a   = total_q;
		alu_req.b   = rdata;
		alu_req.sub = flags_s1.sub;
		raddr       = pt_addr;
		ram_we      = 1'b0;
		case (state_q)
			ST_LADD: begin
				alu_req.a   = crs_q;
				alu_req.b   = {{(SumW-32){1'b0}}, val_q};
				alu_req.sub = 1'b0;
				raddr       = {load_row_q, load_col_q - ColW'(1)};
			end
			ST_LWR: begin
				alu_req.a   = (load_col_q == '0) ? '0 : rdata;
				alu_req.b   = crs_q;
				alu_req.sub = 1'b0;
				ram_we      = 1'b1;
			end
			default: begin
			end
		endcase
	end

	wsaq_alu u_alu (
		.req (alu_req),
		.sum (alu_sum)
	);

	wsaq_ram #(
		.Width (SumW),
		.Depth (2 ** AddrW)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr ({load_row_q, load_col_q}),
		.wdata (alu_sum),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign emit_go = (state_q == ST_EMIT) && (!out_valid_q || result.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			grid_cols_q <= 9'd256;
			grid_rows_q <= 9'd256;
			load_col_q  <= '0;
			load_row_q  <= '0;
			crs_q       <= '0;
			total_q     <= '0;
			out_valid_q <= 1'b0;
			v_s1        <= 1'b0;
		end else begin
			if (wr_en) begin
				case (wr_index)
					wsaq_pkg::CFG_GRID_COLS: grid_cols_q <= wr_data;
					wsaq_pkg::CFG_GRID_ROWS: grid_rows_q <= wr_data;
					default: begin
					end
				endcase
			end
			if (emit_go) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (v_s1 && !flags_s1.zero) begin
				total_q <= alu_sum;
			end
			v_s1 <= (state_q == ST_QRUN);
			case (state_q)
				ST_IDLE: begin
					step_q <= '0;
					if (item.valid) begin
						state_q <= (item.mode == wsaq_pkg::MODE_LOAD) ? ST_LADD : ST_QRUN;
					end
				end
				ST_LADD: begin
					crs_q   <= alu_sum;
					state_q <= ST_LWR;
				end
				ST_LWR: begin
					if (row_wrap) begin
						load_row_q <= '0;
						crs_q      <= '0;
						load_col_q <= col_wrap ? '0 : load_col_q + ColW'(1);
					end else begin
						load_row_q <= load_row_q + RowW'(1);
					end
					state_q <= ST_IDLE;
				end
				ST_QRUN: begin
					step_q <= step_q + 3'd1;
					if (step_q == wsaq_pkg::STEP_LAST) begin
						state_q <= ST_QDRAIN;
					end
				end
				ST_QDRAIN: begin
					state_q <= last_q ? ST_EMIT : ST_IDLE;
				end
				ST_EMIT: begin
					if (emit_go) begin
						total_q <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			val_q   <= item.pixel_value[31] ? 32'd0 : item.pixel_value;
			rects_q <= rects_in;
			last_q  <= item.last_row;
		end
		flags_s1 <= pt_flags;
		if (emit_go) begin
			out_data_q <= total_q;
		end
	end

	a_acc_only_in_query: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 |-> (state_q == ST_QRUN || state_q == ST_QDRAIN))
		else $error("corner accumulate outside query");

	a_partial_kernel_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QDRAIN && !last_q) |=> (state_q == ST_IDLE))
		else $error("non-final rectangle did not return to idle");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit_go |=> (out_valid_q && total_q == '0))
		else $error("emitted total not presented or not cleared");

endmodule

`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for wrapped_summed_area_query_unit.
// Loads grids, queries kernels and compares each total against an in-bench summed-area
// predictor; depends on wsaq_pkg, wsaq_item_if, wsaq_result_if and the unit itself.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SumW = wsaq_pkg::SumW;
	localparam int MaxCols = 256;
	localparam int MaxRows = 256;
	localparam int SettleCycles = 16;
	localparam int HoldCycles = 400;
	localparam int CycleLimit = 1_000_000;

	typedef struct {
		logic               mode;
		logic signed [31:0] pixel_value;
		logic        [7:0]  center_x;
		logic        [7:0]  center_y;
		logic signed [8:0]  west_offset;
		logic        [7:0]  east_offset;
		logic signed [8:0]  north_offset;
		logic signed [8:0]  south_offset;
		logic               last_row;
	} grid_item_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       wr_en = 1'b0;
	logic       wr_index = wsaq_pkg::CFG_GRID_COLS;
	logic [8:0] wr_data = '0;

	wsaq_item_if   item_ch ();
	wsaq_result_if result_ch ();

	wrapped_summed_area_query_unit #(
		.MAX_COLS(MaxCols),
		.MAX_ROWS(MaxRows)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(wr_en),
		.wr_index(wr_index),
		.wr_data(wr_data),
		.item(item_ch),
		.result(result_ch)
	);

	// Mirrored block state
	logic [SumW-1:0] sat_mirror [MaxCols*MaxRows];
	logic [SumW-1:0] col_run;
	logic [SumW-1:0] kernel_acc;
	int              load_col;
	int              load_row;
	logic [8:0]      grid_cols_reg;
	logic [8:0]      grid_rows_reg;
	logic [SumW-1:0] pending_totals [$];

	bit source_no_gaps = 1'b0;
	bit sink_no_stall = 1'b0;
	int sink_hold = 0;
	int cycle_count = 0;
	int n_mismatch = 0;
	int n_loads = 0;
	int n_rects = 0;
	int n_totals = 0;
	int n_sizes = 0;

	always #5 clk = ~clk;

	function automatic int cols_in_use();
		if (grid_cols_reg < 2) return 2;
		if (grid_cols_reg > MaxCols) return MaxCols;
		return int'(grid_cols_reg);
	endfunction

	function automatic int rows_in_use();
		if (grid_rows_reg < 1) return 1;
		if (grid_rows_reg > MaxRows) return MaxRows;
		return int'(grid_rows_reg);
	endfunction

	function automatic logic [SumW-1:0] sat_entry(int x, int y, int c, int r);
		if (x < 0 || y < 0) return '0;
		if (x >= c) x = c - 1;
		if (y >= r) y = r - 1;
		return sat_mirror[y*MaxCols + x];
	endfunction

	function automatic logic [SumW-1:0] rect_area_sum(int w, int e, int n, int s, int c, int r);
		return sat_entry(e, s, c, r) - sat_entry(e, n, c, r)
		     - sat_entry(w, s, c, r) + sat_entry(w, n, c, r);
	endfunction

	function automatic void update_area_state(grid_item_t it);
		int c, r, cx, cy, eo, w, e, n, s;
		logic [SumW-1:0] gain, left;
		c = cols_in_use();
		r = rows_in_use();
		if (it.mode == wsaq_pkg::MODE_LOAD) begin
			gain = it.pixel_value[31] ? '0 : {16'd0, it.pixel_value};
			col_run = col_run + gain;
			left = (load_col > 0) ? sat_mirror[load_row*MaxCols + load_col - 1] : '0;
			sat_mirror[load_row*MaxCols + load_col] = left + col_run;
			load_row++;
			if (load_row >= r) begin
				load_row = 0;
				col_run = '0;
				load_col++;
				if (load_col >= c) load_col = 0;
			end
			n_loads++;
		end else begin
			cx = it.center_x;
			cy = it.center_y;
			eo = it.east_offset;
			w = cx + it.west_offset;
			e = cx + eo;
			n = cy + it.north_offset;
			s = cy + it.south_offset;
			if (eo == c / 2) begin
				gain = rect_area_sum(-1, c - 1, n, s, c, r);
			end else if (w < -1) begin
				gain = rect_area_sum(-1, e, n, s, c, r) + rect_area_sum(c + w, c - 1, n, s, c, r);
			end else if (e >= c) begin
				gain = rect_area_sum(w, c - 1, n, s, c, r) + rect_area_sum(-1, e - c, n, s, c, r);
			end else begin
				gain = rect_area_sum(w, e, n, s, c, r);
			end
			kernel_acc = kernel_acc + gain;
			if (it.last_row) begin
				pending_totals.push_back(kernel_acc);
				kernel_acc = '0;
			end
			n_rects++;
		end
	endfunction

	function automatic grid_item_t random_fields();
		grid_item_t it;
		it.mode = 1'($urandom());
		it.pixel_value = $urandom();
		it.center_x = 8'($urandom());
		it.center_y = 8'($urandom());
		it.west_offset = 9'($urandom());
		it.east_offset = 8'($urandom());
		it.north_offset = 9'($urandom());
		it.south_offset = 9'($urandom());
		it.last_row = 1'($urandom());
		return it;
	endfunction

	function automatic grid_item_t random_load();
		grid_item_t it;
		it = random_fields();
		it.mode = wsaq_pkg::MODE_LOAD;
		case ($urandom_range(0, 9))
			0: it.pixel_value = 32'h7FFF_FFFF;
			1: it.pixel_value = 32'h8000_0000;
			2, 3, 4: ;
			default: it.pixel_value = {1'b0, 31'($urandom())};
		endcase
		return it;
	endfunction

	function automatic grid_item_t make_rect(int cx, int cy, int wo, int eo, int no, int so,
	                                         bit last);
		grid_item_t it;
		it = random_fields();
		it.mode = wsaq_pkg::MODE_QUERY;
		it.center_x = 8'(cx);
		it.center_y = 8'(cy);
		it.west_offset = 9'(wo);
		it.east_offset = 8'(eo);
		it.north_offset = 9'(no);
		it.south_offset = 9'(so);
		it.last_row = last;
		return it;
	endfunction

	// Mostly rectangles around the grid; one in ten keeps fully random offsets.
	function automatic grid_item_t random_rect(int c, int r, bit last);
		grid_item_t it;
		int cx, cy, a, b, lo, hi, reach, span;
		it = random_fields();
		it.mode = wsaq_pkg::MODE_QUERY;
		it.last_row = last;
		if ($urandom_range(0, 9) != 0) begin
			cx = $urandom_range(0, c - 1);
			cy = $urandom_range(0, r - 1);
			reach = (c > 255) ? 256 : c + 1;
			span = (r > 255) ? 256 : r + 1;
			a = int'($urandom_range(0, span)) - 1;
			b = int'($urandom_range(0, span)) - 1;
			lo = (a < b) ? a : b;
			hi = (a < b) ? b : a;
			it.center_x = 8'(cx);
			it.center_y = 8'(cy);
			it.west_offset = 9'(-int'($urandom_range(0, reach)));
			if ($urandom_range(0, 4) == 0) it.east_offset = 8'(c / 2);
			else it.east_offset = 8'($urandom_range(0, (c < 128) ? c : 128));
			if ($urandom_range(0, 9) == 0) begin
				it.north_offset = 9'(hi - cy);
				it.south_offset = 9'(lo - cy);
			end else begin
				it.north_offset = 9'(lo - cy);
				it.south_offset = 9'(hi - cy);
			end
		end
		return it;
	endfunction

	task automatic push_item(grid_item_t it);
		int gap;
		gap = source_no_gaps ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.mode <= it.mode;
		item_ch.pixel_value <= it.pixel_value;
		item_ch.center_x <= it.center_x;
		item_ch.center_y <= it.center_y;
		item_ch.west_offset <= it.west_offset;
		item_ch.east_offset <= it.east_offset;
		item_ch.north_offset <= it.north_offset;
		item_ch.south_offset <= it.south_offset;
		item_ch.last_row <= it.last_row;
		do @(posedge clk); while (!item_ch.ready);
		update_area_state(it);
	endtask

	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (pending_totals.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_grid_size(int cols_val, int rows_val);
		wr_en <= 1'b1;
		wr_index <= wsaq_pkg::CFG_GRID_COLS;
		wr_data <= 9'(cols_val);
		@(posedge clk);
		grid_cols_reg = 9'(cols_val);
		wr_index <= wsaq_pkg::CFG_GRID_ROWS;
		wr_data <= 9'(rows_val);
		@(posedge clk);
		grid_rows_reg = 9'(rows_val);
		wr_en <= 1'b0;
		n_sizes++;
	endtask

	// Finish any load under way, then load the whole grid from its origin.
	task automatic fill_grid();
		int cells;
		while (load_col != 0 || load_row != 0) push_item(random_load());
		cells = cols_in_use() * rows_in_use();
		repeat (cells) push_item(random_load());
	endtask

	task automatic run_kernels(int n_items);
		int left, k, c, r;
		bit burst;
		c = cols_in_use();
		r = rows_in_use();
		left = n_items;
		while (left > 0) begin
			burst = ($urandom_range(0, 4) == 0);
			source_no_gaps = burst;
			sink_no_stall = burst;
			k = $urandom_range(1, 4);
			for (int i = 0; i < k; i++) begin
				if ($urandom_range(0, 19) == 0) push_item(random_load());
				push_item(random_rect(c, r, i == k - 1));
				left--;
			end
		end
		source_no_gaps = 1'b0;
		sink_no_stall = 1'b0;
	endtask

	task automatic test_directed_queries();
		logic signed [31:0] values [6];
		grid_item_t it;
		values = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
		           32'hFFFF_FFFF, 32'h0000_0001, 32'h00AB_CDEF};
		set_grid_size(3, 2);
		foreach (values[i]) begin
			it = random_load();
			it.pixel_value = values[i];
			push_item(it);
		end
		push_item(make_rect(1, 1, -1, 0, -1, 0, 1));
		push_item(make_rect(0, 0, -1, 2, -1, 1, 1));
		push_item(make_rect(2, 0, 0, 1, -1, 1, 1));
		push_item(make_rect(0, 1, -3, 0, -2, 0, 1));
		push_item(make_rect(2, 0, -1, 2, -1, 1, 0));
		push_item(make_rect(1, 0, -2, 0, -1, 0, 1));
		push_item(make_rect(255, 255, 0, 0, 0, 255, 1));
		push_item(make_rect(255, 0, -256, 128, -256, 255, 1));
		push_item(make_rect(0, 255, 0, 0, 255, -256, 0));
		push_item(make_rect(1, 1, -2, 0, 0, -1, 1));
		push_item(make_rect(0, 0, -256, 0, -1, 1, 1));
		push_item(make_rect(128, 0, 0, 128, -1, 0, 1));
		wait_idle();
	endtask

	// Limits of both registers, written in range and out of range.
	task automatic test_register_extremes();
		int sizes [3][2];
		sizes = '{'{2, 1}, '{0, 300}, '{511, 0}};
		foreach (sizes[i]) begin
			set_grid_size(sizes[i][0], sizes[i][1]);
			fill_grid();
			run_kernels(12);
			wait_idle();
		end
	endtask

	task automatic test_shrink_during_load();
		set_grid_size(8, 8);
		fill_grid();
		repeat (45) push_item(random_load());
		wait_idle();
		set_grid_size(4, 3);
		fill_grid();
		run_kernels(15);
		wait_idle();
	endtask

	task automatic test_output_backpressure();
		int c, r;
		c = cols_in_use();
		r = rows_in_use();
		sink_hold = HoldCycles;
		source_no_gaps = 1'b1;
		repeat (30) push_item(random_rect(c, r, 1'b1));
		source_no_gaps = 1'b0;
		wait_idle();
	endtask

	task automatic test_random_kernels();
		int cols_val, rows_val;
		repeat (4) begin
			case ($urandom_range(0, 5))
				0: begin
					cols_val = $urandom_range(0, 511);
					rows_val = $urandom_range(0, 1);
				end
				1: begin
					cols_val = $urandom_range(2, 16);
					rows_val = $urandom_range(1, 8);
				end
				default: begin
					cols_val = $urandom_range(2, 10);
					rows_val = $urandom_range(1, 10);
				end
			endcase
			set_grid_size(cols_val, rows_val);
			fill_grid();
			run_kernels(30);
			wait_idle();
		end
	endtask

	initial begin : receiver
		int wait_left;
		wait_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (result_ch.valid && result_ch.ready)
				wait_left = sink_no_stall ? 0 : $urandom_range(0, 4);
			if (sink_hold > 0) begin
				sink_hold--;
				result_ch.ready <= 1'b0;
			end else if (wait_left > 0) begin
				wait_left--;
				result_ch.ready <= 1'b0;
			end else begin
				result_ch.ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : check_totals
		logic [SumW-1:0] want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			n_totals++;
			if (pending_totals.size() == 0) begin
				$display("%0t ns: total_sum expected none, got %h", $time, result_ch.total_sum);
				n_mismatch++;
			end else begin
				want = pending_totals.pop_front();
				if (result_ch.total_sum !== want) begin
					$display("%0t ns: total_sum expected %h, got %h",
					         $time, want, result_ch.total_sum);
					n_mismatch++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("%0t ns: timeout, %0d totals outstanding", $time, pending_totals.size());
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		item_ch.valid <= 1'b0;
		item_ch.mode <= wsaq_pkg::MODE_LOAD;
		item_ch.pixel_value <= '0;
		item_ch.center_x <= '0;
		item_ch.center_y <= '0;
		item_ch.west_offset <= '0;
		item_ch.east_offset <= '0;
		item_ch.north_offset <= '0;
		item_ch.south_offset <= '0;
		item_ch.last_row <= 1'b0;
		col_run = '0;
		kernel_acc = '0;
		load_col = 0;
		load_row = 0;
		grid_cols_reg = 9'd256;
		grid_rows_reg = 9'd256;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_queries();
		test_register_extremes();
		test_shrink_during_load();
		test_output_backpressure();
		test_random_kernels();
		$display("Ran %0d grid loads and %0d query rectangles, %0d kernel totals checked,",
		         n_loads, n_rects, n_totals);
		$display("over %0d grid sizes incl. saturated ones, a mid-load resize and a %0d-cycle stall.",
		         n_sizes, HoldCycles);
		if (n_mismatch == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

`default_nettype wire

FILE: filelist.f
hdl/wsaq_pkg.sv
hdl/wsaq_item_if.sv
hdl/wsaq_result_if.sv
hdl/wsaq_ram.sv
hdl/wsaq_alu.sv
hdl/wsaq_point.sv
hdl/wrapped_summed_area_query_unit.sv
test/tb.sv
